// ===== sv/sync_frame_parser_sum8_macros.svh =====
// Assertion macros shared by the frame parser RTL.
`ifndef SYNC_FRAME_PARSER_SUM8_MACROS_SVH
`define SYNC_FRAME_PARSER_SUM8_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define SFP_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("frame parser check failed");

// Check that a consequent holds in the cycle after its antecedent.
`define SFP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame parser check failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define SFP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame parser check failed");

`endif

// ===== sv/sfp_pkg.sv =====
// Constants and types of the sync frame parser.
package sfp_pkg;

   localparam logic [7:0] SYNC_A     = 8'hAA;
   localparam logic [7:0] SYNC_B     = 8'h55;
   localparam logic [7:0] HEADER_SUM = 8'hFF;

   localparam int unsigned PAYLOAD_DEPTH = 9;
   localparam int unsigned POS_W         = 4;

   // Frame offsets of interest.
   localparam logic [POS_W-1:0] POS_HUNT   = 4'd0;
   localparam logic [POS_W-1:0] POS_SYNC_B = 4'd1;
   localparam logic [POS_W-1:0] POS_FIRST  = 4'd2;
   localparam logic [POS_W-1:0] POS_LAST   = 4'd10;
   localparam logic [POS_W-1:0] POS_CHECK  = 4'd11;

   typedef struct packed {
      logic [7:0]  seq_number;
      logic [7:0]  flag_bits;
      logic [15:0] ball_pos;
      logic [15:0] target_pos;
      logic [15:0] score_raw;
      logic [7:0]  mode_byte;
   } result_type;

endpackage

// ===== sv/sync_frame_parser_sum8.sv =====
// Top level of the sync frame parser: header hunt, payload capture and sum check.
//
// Usage: feed received bytes on req_rx_byte with req_valid; a byte transfers on a
// rising edge with req_valid high and req_stall low. The parser hunts for the
// header 0xAA 0x55, captures frame offsets 2..10 and compares offset 11 with the
// 8-bit sum of offsets 0..10. A matching frame yields one transfer on the rsp_
// channel carrying sequence, flags, three little-endian 16-bit values and mode;
// a mismatching frame is dropped without notice.
// Throughput: one byte per cycle while req_stall is low. A result is registered in
// the output register, or in the skid register while rsp_stall holds the output.
// Per-byte work is a compare, an 8-bit add and a store between state and result registers.
// When the receiver holds rsp_stall, the pending result stays in the output
// register and a second result goes to a one-entry skid register; req_stall is
// raised only while that skid register is full.
// Reset (synchronous, active high) returns the parser to the hunt, clears the
// running sum and empties the output and skid registers.
module sync_frame_parser_sum8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_seq_number,
   output logic [7:0]  rsp_flag_bits,
   output logic [15:0] rsp_ball_pos,
   output logic [15:0] rsp_target_pos,
   output logic [15:0] rsp_score_raw,
   output logic [7:0]  rsp_mode_byte
);
   import sfp_pkg::*;
   `include "sync_frame_parser_sum8_macros.svh"

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       store_ff [PAYLOAD_DEPTH];
   logic             store_we;
   logic [POS_W-1:0] store_idx;
   logic             req_xfer;
   logic             rsp_xfer;
   logic             hit;
   logic             header_xfer;
   logic             check_xfer;
   result_type       result;
   result_type       out_ff, out_in;
   result_type       skid_ff, skid_in;
   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;

   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = out_valid_ff && !rsp_stall;
   assign store_idx = pos_ff - POS_FIRST;

   // Advance the frame position and running sum for each byte transfer.
   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      store_we = 1'b0;
      hit      = 1'b0;
      if (req_xfer) begin
         if (pos_ff == POS_SYNC_B) begin
            if (req_rx_byte == SYNC_B) begin
               pos_in = POS_FIRST;
               sum_in = HEADER_SUM;
            end else if (req_rx_byte == SYNC_A) begin
               pos_in = POS_SYNC_B;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff >= POS_FIRST && pos_ff <= POS_LAST) begin
            store_we = 1'b1;
            sum_in   = sum_ff + req_rx_byte;
            pos_in   = pos_ff + 4'd1;
         end else if (pos_ff == POS_CHECK) begin
            pos_in = POS_HUNT;
            hit    = (sum_ff == req_rx_byte);
         end else begin
            // Hunt, also for positions past the frame end.
            pos_in = (req_rx_byte == SYNC_A) ? POS_SYNC_B : POS_HUNT;
         end
      end
   end

   // Assemble the result from the captured payload.
   always_comb begin
      result.seq_number = store_ff[0];
      result.flag_bits  = store_ff[1];
      result.ball_pos   = {store_ff[3], store_ff[2]};
      result.target_pos = {store_ff[5], store_ff[4]};
      result.score_raw  = {store_ff[7], store_ff[6]};
      result.mode_byte  = store_ff[8];
   end

   // Steer results through the output register and the skid register.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_xfer) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (hit) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (hit) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   // Hold control state; clear it on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_HUNT;
         sum_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         sum_ff        <= sum_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Capture payload bytes and result data.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_idx] <= req_rx_byte;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_seq_number = out_ff.seq_number;
   assign rsp_flag_bits  = out_ff.flag_bits;
   assign rsp_ball_pos   = out_ff.ball_pos;
   assign rsp_target_pos = out_ff.target_pos;
   assign rsp_score_raw  = out_ff.score_raw;
   assign rsp_mode_byte  = out_ff.mode_byte;

   // Header completion and checksum byte transfers, for the checks below.
   assign header_xfer = req_xfer && pos_ff == POS_SYNC_B && req_rx_byte == SYNC_B;
   assign check_xfer  = req_xfer && pos_ff == POS_CHECK;

   // Checks on the parser's own logic.
   `SFP_ASSERT_ALWAYS(a_pos_in_frame, pos_ff <= POS_CHECK)
   `SFP_ASSERT_NEXT(a_header_load, header_xfer, pos_ff == POS_FIRST && sum_ff == HEADER_SUM)
   `SFP_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_ff || out_valid_ff)
   `SFP_ASSERT_SAME(a_result_from_check, $rose(out_valid_ff), $past(check_xfer))
   `SFP_ASSERT_SAME(a_skid_only_stalled, $rose(skid_valid_ff), $past(rsp_stall))

endmodule
